// ===== design/bpeq_pkg.sv =====
// Package for the biquad peaking EQ filter: widths, microcode types,
// register indexes and control structs shared by all design files.
// No dependencies.
`timescale 1ns / 1ps

package bpeq_pkg;

  // Default values of the top-level parameters
  localparam int SAMPLE_WIDTH_DEF   = 24;
  localparam int COEF_FRAC_BITS_DEF = 26;

  // Fixed widths: coefficients and node values are 32-bit signed
  localparam int COEF_W = 32;
  localparam int NODE_W = 32;
  localparam int PROD_W = COEF_W + NODE_W;
  // Three products plus the input term and rounding half fit with margin
  localparam int ACC_W  = PROD_W + 2;

  // Configuration port
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_B0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_B2 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_A1 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_A2 = CFG_IDX_W'(3);

  // Microcode program counter
  localparam int PC_W = 3;

  // Multiplier operand pair
  typedef enum logic [1:0] {
    MUL_A1Z1,
    MUL_A2Z2,
    MUL_B2Z2,
    MUL_B0M
  } mul_sel_t;

  // Accumulator operation
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_SUB,
    ACC_LOAD_P,
    ACC_ADD
  } acc_op_t;

  // Condition that lets a step complete
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_IN,
    COND_OUT
  } cond_t;

  // One microcode word
  typedef struct packed {
    mul_sel_t        mul_sel;
    acc_op_t         acc_op;
    logic            latch_m;
    logic            write_out;
    cond_t           cond;
    logic            jump;
    logic [PC_W-1:0] target;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    ucode_t uc;
    logic   go;
    logic   in_ready;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic out_free;
  } status_t;

endpackage

// ===== design/bpeq_if.sv =====
// Channel interfaces for the biquad peaking EQ filter: sample input,
// sample output and configuration write. Depends on bpeq_pkg.
`timescale 1ns / 1ps

interface bpeq_in_if #(parameter int W = bpeq_pkg::SAMPLE_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface bpeq_out_if #(parameter int W = bpeq_pkg::SAMPLE_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface bpeq_cfg_if;
  import bpeq_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [CFG_IDX_W-1:0]        index;
  logic signed [COEF_W-1:0]    wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== design/bpeq_seq.sv =====
// Microcode sequencer: program table, step counter and jump logic.
// Depends on bpeq_pkg.
`timescale 1ns / 1ps

module bpeq_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  bpeq_pkg::status_t  status,
  output bpeq_pkg::ctrl_t    ctrl
);
  import bpeq_pkg::*;

  localparam logic [PC_W-1:0] STEP_ACCEPT = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_LAST   = PC_W'(5);

  logic [PC_W-1:0] pc_r, pc_nxt;
  ucode_t          uc;
  logic            go;

  // Program: node value m in steps 0..3, output y in steps 3..5
  function automatic ucode_t rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      PC_W'(0): w = '{MUL_A1Z1, ACC_LOAD_X, 1'b0, 1'b0, COND_IN,     1'b0, STEP_ACCEPT};
      PC_W'(1): w = '{MUL_A2Z2, ACC_SUB,    1'b0, 1'b0, COND_ALWAYS, 1'b0, STEP_ACCEPT};
      PC_W'(2): w = '{MUL_A1Z1, ACC_SUB,    1'b0, 1'b0, COND_ALWAYS, 1'b0, STEP_ACCEPT};
      PC_W'(3): w = '{MUL_B2Z2, ACC_LOAD_P, 1'b1, 1'b0, COND_ALWAYS, 1'b0, STEP_ACCEPT};
      PC_W'(4): w = '{MUL_B0M,  ACC_ADD,    1'b0, 1'b0, COND_ALWAYS, 1'b0, STEP_ACCEPT};
      PC_W'(5): w = '{MUL_B0M,  ACC_ADD,    1'b0, 1'b1, COND_OUT,    1'b1, STEP_ACCEPT};
      default:  w = '{MUL_A1Z1, ACC_HOLD,   1'b0, 1'b0, COND_ALWAYS, 1'b1, STEP_ACCEPT};
    endcase
    return w;
  endfunction

  // Step completion condition
  always_comb begin
    uc = rom(pc_r);
    case (uc.cond)
      COND_ALWAYS: go = 1'b1;
      COND_IN:     go = status.in_valid;
      COND_OUT:    go = status.out_free;
      default:     go = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    pc_nxt = pc_r;
    if (go) begin
      pc_nxt = uc.jump ? uc.target : pc_r + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_ACCEPT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl.uc       = uc;
  assign ctrl.go       = go;
  assign ctrl.in_ready = (uc.cond == COND_IN);

`ifndef SYNTHESIS
  a_ready_at_accept_step: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.in_ready |-> (pc_r == STEP_ACCEPT))
    else $error("input ready outside the accept step");
  a_back_to_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (go && uc.write_out) |=> (pc_r == STEP_ACCEPT))
    else $error("sequencer did not return after the output write");
  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= STEP_LAST)
    else $error("step counter left the program");
`endif

endmodule

// ===== design/bpeq_datapath.sv =====
// Datapath: coefficient registers, shared 32x32 multiplier, accumulator,
// node delay registers and output register. Depends on bpeq_pkg, bpeq_if.
`timescale 1ns / 1ps

module bpeq_datapath #(
  parameter int SAMPLE_WIDTH   = bpeq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bpeq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bpeq_pkg::ctrl_t   ctrl,
  output bpeq_pkg::status_t status,
  bpeq_in_if.sink           in_chan,
  bpeq_out_if.source        out_chan,
  bpeq_cfg_if.sink          cfg_chan
);
  import bpeq_pkg::*;

  localparam logic signed [COEF_W-1:0] B0_RESET = COEF_W'(1) <<< COEF_FRAC_BITS;
  localparam logic signed [ACC_W-1:0]  HALF     = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0]  NODE_MAX =
    $signed({{(ACC_W-NODE_W+1){1'b0}}, {(NODE_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0]  NODE_MIN =
    $signed({{(ACC_W-NODE_W+1){1'b1}}, {(NODE_W-1){1'b0}}});
  localparam logic signed [ACC_W-1:0]  OUT_MAX  =
    $signed({{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}});
  localparam logic signed [ACC_W-1:0]  OUT_MIN  =
    $signed({{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}});

  logic signed [COEF_W-1:0]       b0_r, b2_r, a1_r, a2_r;
  logic signed [NODE_W-1:0]       z1_r, z2_r, m_r;
  logic signed [COEF_W-1:0]       mul_a;
  logic signed [NODE_W-1:0]       mul_b;
  logic signed [PROD_W-1:0]       prod_r;
  logic signed [ACC_W-1:0]        prod_ext, x_ext;
  logic signed [ACC_W-1:0]        acc_r, acc_nxt;
  logic signed [ACC_W-1:0]        m_shift, y_shift;
  logic signed [NODE_W-1:0]       m_sat;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic signed [SAMPLE_WIDTH-1:0] out_data_r;
  logic                           out_valid_r;
  logic                           write_go;

  assign write_go = ctrl.go && ctrl.uc.write_out;

  // Configuration writes; unknown indexes are dropped
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= B0_RESET;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_B0:  b0_r <= cfg_chan.wdata;
        REG_B2:  b2_r <= cfg_chan.wdata;
        REG_A1:  a1_r <= cfg_chan.wdata;
        REG_A2:  a2_r <= cfg_chan.wdata;
        default: ;
      endcase
    end
  end

  // Shared multiplier with registered product
  always_comb begin
    case (ctrl.uc.mul_sel)
      MUL_A1Z1: begin mul_a = a1_r; mul_b = z1_r; end
      MUL_A2Z2: begin mul_a = a2_r; mul_b = z2_r; end
      MUL_B2Z2: begin mul_a = b2_r; mul_b = z2_r; end
      MUL_B0M:  begin mul_a = b0_r; mul_b = m_r;  end
      default:  begin mul_a = a1_r; mul_b = z1_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign x_ext    = {{(ACC_W-SAMPLE_WIDTH){in_chan.sample_in[SAMPLE_WIDTH-1]}},
                     in_chan.sample_in};

  // Accumulator
  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.go) begin
      case (ctrl.uc.acc_op)
        ACC_HOLD:   acc_nxt = acc_r;
        ACC_LOAD_X: acc_nxt = (x_ext <<< COEF_FRAC_BITS) + HALF;
        ACC_SUB:    acc_nxt = acc_r - prod_ext;
        ACC_LOAD_P: acc_nxt = HALF + prod_ext;
        ACC_ADD:    acc_nxt = acc_r + prod_ext;
        default:    acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Node value: floor shift of the rounded sum, saturated to 32 bits
  always_comb begin
    m_shift = acc_r >>> COEF_FRAC_BITS;
    if (m_shift > NODE_MAX) begin
      m_sat = NODE_MAX[NODE_W-1:0];
    end else if (m_shift < NODE_MIN) begin
      m_sat = NODE_MIN[NODE_W-1:0];
    end else begin
      m_sat = m_shift[NODE_W-1:0];
    end
  end

  // Output: final sum taken straight from the accumulator input
  always_comb begin
    y_shift = acc_nxt >>> COEF_FRAC_BITS;
    if (y_shift > OUT_MAX) begin
      y_sat = OUT_MAX[SAMPLE_WIDTH-1:0];
    end else if (y_shift < OUT_MIN) begin
      y_sat = OUT_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      y_sat = y_shift[SAMPLE_WIDTH-1:0];
    end
  end

  // Node value latch and delay line
  always_ff @(posedge clk) begin
    if (ctrl.go && ctrl.uc.latch_m) begin
      m_r <= m_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z1_r <= '0;
      z2_r <= '0;
    end else if (write_go) begin
      z2_r <= z1_r;
      z1_r <= m_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (write_go) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (write_go) begin
      out_data_r <= y_sat;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_data_r;
  assign in_chan.ready       = ctrl.in_ready;

  assign status.in_valid = in_chan.valid;
  assign status.out_free = !out_valid_r || out_chan.ready;

`ifndef SYNTHESIS
  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    write_go |=> out_valid_r)
    else $error("output write did not raise valid");
  a_delay_shift: assert property (@(posedge clk) disable iff (!rst_n)
    write_go |=> (z2_r == $past(z1_r)) && (z1_r == $past(m_r)))
    else $error("node delay line did not shift");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    write_go |-> (!out_valid_r || out_chan.ready))
    else $error("output overwritten before transfer");
`endif

endmodule

// ===== design/biquad_peaking_eq_filter.sv =====
// Top level of the biquad peaking EQ filter: microcode sequencer and
// datapath. Depends on bpeq_pkg, bpeq_if, bpeq_seq, bpeq_datapath.
`timescale 1ns / 1ps

// Direct form II biquad, one output sample per input sample. A six-step
// microcode program drives a single 32x32 multiplier (product registered)
// and an accumulator, and the five products per sample pass through that
// multiplier one per step. The input transfer happens in the first step;
// the last step waits while a previous result is still held in the output
// register and not taken. Coefficients are signed Q6.26 (b1 equals a1);
// the user must write them through the configuration port only while no
// sample is in flight, as the block does not enforce this. After reset the
// filter is a passthrough. Node values saturate to 32 bits, outputs to the
// sample width, with sums rounded to nearest, halves upward.
module biquad_peaking_eq_filter #(
  parameter int SAMPLE_WIDTH   = bpeq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bpeq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bpeq_in_if.sink     in_chan,
  bpeq_out_if.source  out_chan,
  bpeq_cfg_if.sink    cfg_chan
);
  import bpeq_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  bpeq_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  bpeq_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .status   (status),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

endmodule
